### hdl/block_pool_first_fit_allocator_defines.svh
// Assertion macros for the block pool allocator.
`ifndef BLOCK_POOL_FIRST_FIT_ALLOCATOR_DEFINES_SVH
`define BLOCK_POOL_FIRST_FIT_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, checked on clk, off while arst_n is low.
`define BPA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on clk, off while arst_n is low.
`define BPA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/bpa_pkg.sv
`default_nettype none

package bpa_pkg;

	// command codes
	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	// result status codes
	localparam logic [1:0] ST_ALLOC   = 2'd0;
	localparam logic [1:0] ST_FREED   = 2'd1;
	localparam logic [1:0] ST_FAIL    = 2'd2;
	localparam logic [1:0] ST_IGNORED = 2'd3;

	typedef struct packed {
		logic        command;
		logic [15:0] request_bytes;
		logic [15:0] release_offset;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [10:0] grant_offset;
		logic [5:0]  block_count;
	} rsp_t;

	// per-block bookkeeping held in the table RAM
	typedef struct packed {
		logic free;
		logic chained;
	} blk_t;

endpackage

`default_nettype wire

### hdl/block_pool_first_fit_allocator.sv
// Allocate scans the block table for the first free run that fits and marks it used;
// free divides the offset by the block size, range-checks it and walks the chain.
// A zero-size allocate fails at once. Only one transaction is in flight at a time; the
// scan and chain walk read the block table RAM one entry per cycle.
// Reset: arst_n clears control; then the CLEAR state clears the table, req_ready low.
`default_nettype none
`include "block_pool_first_fit_allocator_defines.svh"

module block_pool_first_fit_allocator #(
	parameter int NUM_BLOCKS  = 32,
	parameter int BLOCK_BYTES = 64
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 req_valid,
	output logic                req_ready,
	input  wire bpa_pkg::req_t  req,
	output logic                rsp_valid,
	input  wire                 rsp_ready,
	output bpa_pkg::rsp_t       rsp
);

	localparam int IDX_W  = $clog2(NUM_BLOCKS);
	localparam int CNT_RAW = $clog2(NUM_BLOCKS + 1);
	// count kept at least 6 bits wide so the result field is a plain part-select
	localparam int CNT_W  = (CNT_RAW > 6) ? CNT_RAW : 6;
	localparam int OFF_W  = IDX_W + 13;
	localparam int BLK_W  = $bits(bpa_pkg::blk_t);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BLOCKS - 1);
	localparam logic [12:0]      BB_V     = 13'(BLOCK_BYTES);
	// floor(2^32 / BLOCK_BYTES): quotient estimate is exact or one low
	localparam logic [31:0]      RECIP    = 32'((64'd1 << 32) / BLOCK_BYTES);

	typedef enum logic [3:0] {
		CLEAR,      // post-reset sweep: every block free, unchained
		IDLE,
		SCAN_RD,    // first table read for an allocate
		SCAN,       // one block per cycle, looking for a free run
		WRITE,      // mark the found run used, chained up to its last block
		DIV1,       // offset * reciprocal
		DIV2,       // estimate * block size
		DIV3,       // correct estimate, range check
		FREE_RD,    // first table read for a free
		FREE_WALK,  // release one block per cycle along the chain
		DONE        // park result in the output register
	} state_t;

	state_t              state_q;
	logic [IDX_W-1:0]    idx_q;      // current block (clear, scan, write, walk)
	logic [IDX_W-1:0]    last_q;     // last block of the found run
	logic [IDX_W-1:0]    head_q;     // first block of the current/found run
	logic [CNT_W-1:0]    run_q;      // run length, then block count of the result
	logic [16:0]         run_bytes_q;
	logic [15:0]         bytes_q;
	logic [15:0]         offs_q;
	logic [15:0]         quot_q;
	logic [28:0]         prod_q;
	logic [1:0]          status_q;
	logic                rsp_valid_q;
	bpa_pkg::rsp_t       rsp_q;

	// table RAM
	logic                we;
	logic [IDX_W-1:0]    waddr;
	bpa_pkg::blk_t       wdata;
	logic [IDX_W-1:0]    raddr;
	bpa_pkg::blk_t       rdata;

	// datapath helpers
	logic [16:0]         acc_bytes;
	logic                run_fits;
	logic [47:0]         recip_prod;
	logic [28:0]         diff;
	logic [16:0]         quot_fix;
	logic [OFF_W-1:0]    off_full;
	logic                rsp_load;

	bpa_ram #(
		.WIDTH (BLK_W),
		.DEPTH (NUM_BLOCKS)
	) u_table (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign req_ready = (state_q == IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Read one block ahead during scan and walk, so each cycle sees the next entry.
	always_comb begin
		if ((state_q == SCAN || state_q == FREE_WALK) && idx_q != LAST_IDX) begin
			raddr = idx_q + IDX_W'(1);
		end else begin
			raddr = idx_q;
		end
	end

	always_comb begin
		we            = 1'b0;
		waddr         = idx_q;
		wdata.free    = 1'b1;
		wdata.chained = 1'b0;
		unique case (state_q)
			CLEAR: begin
				we = 1'b1;
			end
			WRITE: begin
				we            = 1'b1;
				wdata.free    = 1'b0;
				wdata.chained = (idx_q != last_q);
			end
			FREE_WALK: begin
				we = 1'b1;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	// A run fits once its byte capacity covers the request; this avoids a divide.
	assign acc_bytes  = run_bytes_q + 17'(BB_V);
	assign run_fits   = (acc_bytes >= {1'b0, bytes_q});
	assign recip_prod = 48'(offs_q) * 48'(RECIP);
	assign diff       = 29'(offs_q) - prod_q;
	assign quot_fix   = {1'b0, quot_q} + 17'(diff >= 29'(BB_V));
	assign off_full   = OFF_W'(head_q) * OFF_W'(BB_V);
	assign rsp_load   = (state_q == DONE) && (!rsp_valid_q || rsp_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= CLEAR;
			idx_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end

			unique case (state_q)
				CLEAR: begin
					if (idx_q == LAST_IDX) begin
						state_q <= IDLE;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end

				IDLE: begin
					if (req_valid) begin
						bytes_q     <= req.request_bytes;
						offs_q      <= req.release_offset;
						idx_q       <= '0;
						run_q       <= '0;
						run_bytes_q <= '0;
						head_q      <= '0;
						if (req.command == bpa_pkg::CMD_FREE) begin
							state_q <= DIV1;
						end else if (req.request_bytes == 16'd0) begin
							status_q <= bpa_pkg::ST_FAIL;
							state_q  <= DONE;
						end else begin
							state_q <= SCAN_RD;
						end
					end
				end

				SCAN_RD: begin
					state_q <= SCAN;
				end

				SCAN: begin
					if (rdata.free && run_fits) begin
						// the run ends at this block
						run_q   <= run_q + CNT_W'(1);
						last_q  <= idx_q;
						if (run_q == '0) begin
							head_q <= idx_q;
							idx_q  <= idx_q;
						end else begin
							idx_q  <= head_q;
						end
						state_q <= WRITE;
					end else begin
						if (rdata.free) begin
							if (run_q == '0) begin
								head_q <= idx_q;
							end
							run_q       <= run_q + CNT_W'(1);
							run_bytes_q <= acc_bytes;
						end else begin
							// used block breaks the run
							run_q       <= '0;
							run_bytes_q <= '0;
						end
						if (idx_q == LAST_IDX) begin
							status_q <= bpa_pkg::ST_FAIL;
							run_q    <= '0;
							state_q  <= DONE;
						end else begin
							idx_q <= idx_q + IDX_W'(1);
						end
					end
				end

				WRITE: begin
					if (idx_q == last_q) begin
						status_q <= bpa_pkg::ST_ALLOC;
						state_q  <= DONE;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end

				DIV1: begin
					quot_q  <= recip_prod[47:32];
					state_q <= DIV2;
				end

				DIV2: begin
					prod_q  <= 29'(quot_q) * 29'(BB_V);
					state_q <= DIV3;
				end

				DIV3: begin
					if (quot_fix >= 17'(NUM_BLOCKS)) begin
						status_q <= bpa_pkg::ST_IGNORED;
						state_q  <= DONE;
					end else begin
						idx_q   <= quot_fix[IDX_W-1:0];
						state_q <= FREE_RD;
					end
				end

				FREE_RD: begin
					state_q <= FREE_WALK;
				end

				FREE_WALK: begin
					run_q <= run_q + CNT_W'(1);
					if (rdata.chained && idx_q != LAST_IDX) begin
						idx_q <= idx_q + IDX_W'(1);
					end else begin
						status_q <= bpa_pkg::ST_FREED;
						state_q  <= DONE;
					end
				end

				DONE: begin
					if (rsp_load) begin
						rsp_q.status <= status_q;
						rsp_q.grant_offset <= (status_q == bpa_pkg::ST_ALLOC) ?
							off_full[10:0] : 11'd0;
						rsp_q.block_count <= run_q[5:0];
						state_q <= IDLE;
					end
				end

				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

	// A result only appears out of the DONE state.
	`BPA_ASSERT_NOW(a_rsp_from_done, $rose(rsp_valid_q), $past(state_q == DONE), "rsp without DONE")
	// The run write never runs past the end of the found run.
	`BPA_ASSERT_NOW(a_write_bound, state_q == WRITE, idx_q <= last_q, "run write overshoot")
	// One transaction at a time: ready drops right after an accept.
	`BPA_ASSERT_NEXT(a_one_at_time, req_valid && req_ready, !req_ready, "accept while busy")
	// Failed or ignored requests report no blocks and no offset.
	`BPA_ASSERT_NOW(a_fail_zero,
		rsp_valid && (rsp.status == bpa_pkg::ST_FAIL || rsp.status == bpa_pkg::ST_IGNORED),
		rsp.block_count == 6'd0 && rsp.grant_offset == 11'd0, "nonzero fields on failure")

endmodule

`default_nettype wire

### hdl/bpa_ram.sv
`default_nettype none

// Simple dual-port RAM, one write and one registered read port.
module bpa_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 32
) (
	input  wire                     clk,
	input  wire                     we,
	input  wire [$clog2(DEPTH)-1:0] waddr,
	input  wire [WIDTH-1:0]         wdata,
	input  wire [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

### dv/pool_result_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the block pool allocator, keeps its own copy of the
// block table and compares every response against the predicted one.
module pool_result_checker import bpa_pkg::*; #(
	parameter int NUM_BLOCKS  = 32,
	parameter int BLOCK_BYTES = 64
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    req_valid,
	input  wire                    req_ready,
	input  req_t                   req,
	input  wire                    rsp_valid,
	input  wire                    rsp_ready,
	input  rsp_t                   rsp,
	output int                     fail_count,
	output int                     in_flight,
	output int                     results_checked,
	output logic [NUM_BLOCKS-1:0]  free_map,
	output logic [NUM_BLOCKS-1:0]  chain_map
);

	localparam int MAX_REPORTS = 10;

	logic [NUM_BLOCKS-1:0] pool_free;
	logic [NUM_BLOCKS-1:0] pool_chained;
	logic [6:0]            pool_fill [NUM_BLOCKS];

	rsp_t owed_results[$];
	int   mismatches;
	int   seen;

	// Applies one transaction to the shadow table and returns its response.
	function automatic rsp_t serve_request(input req_t r);
		rsp_t o;
		int   need;
		int   rem;
		int   run;
		int   start;
		int   last;
		int   idx;
		int   cnt;
		bit   found;
		o = '0;
		if (r.command == CMD_ALLOC) begin
			o.status = ST_FAIL;
			if (r.request_bytes != 0) begin
				need  = r.request_bytes / BLOCK_BYTES;
				rem   = r.request_bytes % BLOCK_BYTES;
				if (rem != 0)
					need++;
				found = 1'b0;
				run   = 0;
				start = 0;
				// first fit; any used block restarts the run
				for (int i = 0; i < NUM_BLOCKS; i++) begin
					if (!found) begin
						if (pool_free[i]) begin
							if (run == 0)
								start = i;
							run++;
							if (run == need)
								found = 1'b1;
						end else begin
							run = 0;
						end
					end
				end
				if (found) begin
					last = start + need - 1;
					for (int i = start; i <= last; i++) begin
						pool_free[i]    = 1'b0;
						pool_chained[i] = (i != last);
						pool_fill[i]    = 7'((i == last && rem != 0) ? rem : BLOCK_BYTES);
					end
					o.status       = ST_ALLOC;
					o.grant_offset = 11'(start * BLOCK_BYTES);
					o.block_count  = 6'(need);
				end
			end
		end else begin
			idx = r.release_offset / BLOCK_BYTES;
			if (idx >= NUM_BLOCKS) begin
				o.status = ST_IGNORED;
			end else begin
				cnt = 0;
				while (pool_chained[idx] && idx + 1 < NUM_BLOCKS) begin
					pool_free[idx]    = 1'b1;
					pool_chained[idx] = 1'b0;
					pool_fill[idx]    = '0;
					cnt++;
					idx++;
				end
				pool_free[idx]    = 1'b1;
				pool_chained[idx] = 1'b0;
				pool_fill[idx]    = '0;
				o.status      = ST_FREED;
				o.block_count = 6'(cnt + 1);
			end
		end
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			pool_free    = '1;
			pool_chained = '0;
			for (int i = 0; i < NUM_BLOCKS; i++)
				pool_fill[i] = '0;
			owed_results.delete();
			mismatches = 0;
			seen       = 0;
		end else begin
			// response first: nothing accepted on this edge can already be answered
			if (rsp_valid && rsp_ready) begin
				seen++;
				if (owed_results.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("%0t: response with nothing outstanding: status %0d grant %0d count %0d",
							$time, rsp.status, rsp.grant_offset, rsp.block_count);
				end else begin
					want = owed_results.pop_front();
					if (rsp.status !== want.status || rsp.grant_offset !== want.grant_offset ||
							rsp.block_count !== want.block_count) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS)
							$display("%0t: mismatch exp status %0d grant %0d count %0d, got status %0d grant %0d count %0d",
								$time, want.status, want.grant_offset, want.block_count,
								rsp.status, rsp.grant_offset, rsp.block_count);
					end
				end
			end
			if (req_valid && req_ready)
				owed_results.push_back(serve_request(req));
		end
		fail_count      <= mismatches;
		in_flight       <= owed_results.size();
		results_checked <= seen;
		free_map        <= pool_free;
		chain_map       <= pool_chained;
	end

endmodule

### dv/block_pool_first_fit_allocator_tb.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the first-fit block allocator. Prediction and
// comparison live in pool_result_checker; this module only shapes traffic.
module block_pool_first_fit_allocator_tb;
	import bpa_pkg::*;

	localparam int NUM_BLOCKS   = 32;
	localparam int BLOCK_BYTES  = 64;
	localparam int POOL_BYTES   = NUM_BLOCKS * BLOCK_BYTES;

	localparam int RANDOM_ITEMS = 480;
	localparam int PAUSE_AT     = 250;   // sender drains the block here
	localparam int QUIET_FROM   = 400;   // no idling on either side after this
	localparam int HOLD_AT      = 150;   // responses delivered before the long hold-off
	localparam int LONG_HOLD    = 300;   // cycles the receiver holds off
	localparam int TAIL_CYCLES  = 100;   // idle tail after the last response
	localparam int STALL_LIMIT  = 4000;  // hold-off + one transaction, several times over

	logic clk = 1'b0;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	req_t req;
	logic rsp_valid;
	logic rsp_ready;
	rsp_t rsp;

	int                    fail_count;
	int                    in_flight;
	int                    results_checked;
	logic [NUM_BLOCKS-1:0] free_map;
	logic [NUM_BLOCKS-1:0] chain_map;

	bit quiet = 1'b0;
	int n_alloc = 0;
	int n_free = 0;
	int stall_cycles = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	block_pool_first_fit_allocator #(
		.NUM_BLOCKS  (NUM_BLOCKS),
		.BLOCK_BYTES (BLOCK_BYTES)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	pool_result_checker #(
		.NUM_BLOCKS  (NUM_BLOCKS),
		.BLOCK_BYTES (BLOCK_BYTES)
	) checker_i (
		.clk             (clk),
		.arst_n          (arst_n),
		.req_valid       (req_valid),
		.req_ready       (req_ready),
		.req             (req),
		.rsp_valid       (rsp_valid),
		.rsp_ready       (rsp_ready),
		.rsp             (rsp),
		.fail_count      (fail_count),
		.in_flight       (in_flight),
		.results_checked (results_checked),
		.free_map        (free_map),
		.chain_map       (chain_map)
	);

	// The unused field of each request carries random bits so that every input
	// bit toggles without changing the outcome.
	function automatic req_t alloc_req(input logic [15:0] bytes);
		req_t t;
		t.command        = CMD_ALLOC;
		t.request_bytes  = bytes;
		t.release_offset = 16'($urandom);
		return t;
	endfunction

	function automatic req_t free_req(input logic [15:0] offset);
		req_t t;
		t.command        = CMD_FREE;
		t.request_bytes  = 16'($urandom);
		t.release_offset = offset;
		return t;
	endfunction

	// Picks a used block from the shadow maps; with want_head only the first
	// block of a run. The maps lag by one transaction, which only skews choice.
	function automatic int pick_used(input bit want_head);
		int found[$];
		for (int i = 0; i < NUM_BLOCKS; i++)
			if (!free_map[i] && (!want_head || i == 0 || !chain_map[i-1]))
				found.push_back(i);
		if (found.size() == 0)
			return -1;
		return found[$urandom_range(0, found.size() - 1)];
	endfunction

	// Offers one transaction and holds it until accepted. Valid stays high on
	// return unless an idle burst follows, so back-to-back items never drop it.
	task automatic offer(input req_t item);
		req       <= item;
		req_valid <= 1'b1;
		do
			@(posedge clk);
		while (!req_ready);
		if (item.command == CMD_ALLOC)
			n_alloc++;
		else
			n_free++;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
	endtask

	// Random transaction mix: allocations mostly of a few blocks so the pool
	// churns, frees mostly of live run heads; the rest hits middles of runs,
	// already free blocks, unaligned and out-of-range offsets, and junk sizes.
	function automatic req_t random_req();
		int   pick;
		int   blk;
		logic [15:0] bytes;
		logic [15:0] offset;
		pick = $urandom_range(0, 99);
		if (pick < 45) begin
			pick = $urandom_range(0, 99);
			if (pick < 60)
				bytes = 16'($urandom_range(1, 4 * BLOCK_BYTES));
			else if (pick < 85)
				bytes = 16'($urandom_range(1, POOL_BYTES));
			else if (pick < 90)
				bytes = '0;
			else
				bytes = 16'($urandom);
			return alloc_req(bytes);
		end
		pick = $urandom_range(0, 99);
		blk  = -1;
		if (pick < 60)
			blk = pick_used(1'b1);
		else if (pick < 75)
			blk = pick_used(1'b0);
		if (blk >= 0) begin
			offset = 16'(blk * BLOCK_BYTES);
			if ($urandom_range(0, 3) == 0)
				offset = offset + 16'($urandom_range(1, BLOCK_BYTES - 1));
		end else if (pick < 90) begin
			offset = 16'($urandom_range(0, POOL_BYTES - 1));
		end else begin
			offset = 16'($urandom);
		end
		return free_req(offset);
	endfunction

	// Receiver: short random stalls, one long hold-off so the block backs up
	// into its request side, and no stalls once the run goes quiet.
	initial begin : sink
		int  delivered;
		bit  held;
		delivered = 0;
		held      = 1'b0;
		rsp_ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (rsp_valid && rsp_ready)
				delivered++;
			if (!held && delivered >= HOLD_AT) begin
				held = 1'b1;
				rsp_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				rsp_ready <= 1'b1;
			end else if (!quiet && $urandom_range(0, 4) == 0) begin
				rsp_ready <= 1'b0;
				repeat ($urandom_range(1, 3)) @(posedge clk);
				rsp_ready <= 1'b1;
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	// Watchdog: a hang shows up as a long run of cycles with no transaction.
	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin : source
		arst_n    <= 1'b0;
		req_valid <= 1'b0;
		req       <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part. Comments give the expected table effect.
		offer(alloc_req(16'd0));                      // zero size fails
		offer(alloc_req(16'(POOL_BYTES)));            // whole pool in one run
		offer(alloc_req(16'd1));                      // pool full, fails
		offer(free_req(16'd0));                       // chain walks to the last block
		offer(alloc_req(16'(POOL_BYTES + 1)));        // bigger than the pool
		offer(alloc_req(16'hFFFF));                   // largest size
		offer(alloc_req(16'd1));                      // block 0
		offer(alloc_req(16'(BLOCK_BYTES)));           // exactly one block: 1
		offer(alloc_req(16'(BLOCK_BYTES + 1)));       // two blocks: 2-3
		offer(alloc_req(16'd200));                    // four blocks: 4-7
		offer(free_req(16'(BLOCK_BYTES + 37)));       // unaligned offset, frees block 1
		offer(free_req(16'(3 * BLOCK_BYTES)));        // tail of run 2-3; block 2 stays used
		offer(free_req(16'(BLOCK_BYTES)));            // block already free
		offer(alloc_req(16'(2 * BLOCK_BYTES)));       // gaps of 1 are skipped, lands at 8
		offer(free_req(16'(POOL_BYTES)));             // just past the pool, ignored
		offer(free_req(16'hFFFF));                    // far past the pool, ignored
		offer(free_req(16'(POOL_BYTES - 1)));         // last byte of the pool, block free
		offer(free_req(16'(2 * BLOCK_BYTES)));        // stale chain from 2 into 3
		offer(alloc_req(16'(POOL_BYTES - BLOCK_BYTES))); // no run that long, fails
		offer(free_req(16'd0));
		offer(free_req(16'(4 * BLOCK_BYTES)));
		offer(free_req(16'(8 * BLOCK_BYTES)));
		offer(alloc_req(16'(POOL_BYTES - BLOCK_BYTES))); // empty pool: blocks 0-30
		offer(alloc_req(16'(BLOCK_BYTES)));           // last block
		offer(free_req(16'd0));

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == PAUSE_AT) begin
				// hold the sender until every response is back
				req_valid <= 1'b0;
				@(posedge clk);
				while (in_flight != 0)
					@(posedge clk);
			end
			if (n == QUIET_FROM)
				quiet = 1'b1;
			offer(random_req());
		end
		req_valid <= 1'b0;

		@(posedge clk);
		while (in_flight != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Sent %0d allocate and %0d free transactions, %0d responses checked,",
			n_alloc, n_free, results_checked);
		$display("with random stalls, a %0d-cycle response hold-off and a full drain pause.",
			LONG_HOLD);
		if (fail_count == 0 && in_flight == 0) begin
			$display("Regression PASS");
		end else begin
			$display("%0d mismatches, %0d responses outstanding", fail_count, in_flight);
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
